FILE: hw/rtl/tspc_pkg.sv
// ----------------------------------------------------------------------------
// tspc_pkg
// Shared types and constants of the timed shutter position controller.
// ----------------------------------------------------------------------------
package tspc_pkg;

    localparam int unsigned POS_W    = 7;
    localparam int unsigned TRAVEL_W = 20;
    localparam int unsigned STEP_W   = 14;
    localparam int unsigned RECIP_W  = 21;
    localparam int unsigned PROD_W   = TRAVEL_W + RECIP_W;
    localparam int unsigned SHIFT    = 27;
    localparam int unsigned ADDR_W   = 3;
    localparam int unsigned DATA_W   = 32;

    localparam logic [POS_W-1:0]    POS_MAX      = 7'd100;
    localparam logic [TRAVEL_W-1:0] TRAVEL_RESET = 20'd27000;
    localparam logic [STEP_W-1:0]   STEP_RESET   = 14'd270;
    localparam logic [STEP_W-1:0]   TIMER_MAX    = 14'd16383;
    // ceil(2^27 / 100): exact floor(x / 100) for any 20-bit x
    localparam logic [RECIP_W-1:0]  STEP_RECIP   = 21'd1342178;

    localparam logic [0:0] REG_TRAVEL = 1'b0;

    localparam logic [1:0] CMD_NONE = 2'd0;
    localparam logic [1:0] CMD_UP   = 2'd1;
    localparam logic [1:0] CMD_DOWN = 2'd2;
    localparam logic [1:0] CMD_STOP = 2'd3;

    typedef struct packed {
        logic [1:0] command;
        logic       up_button;
        logic       down_button;
    } cmd_t;

    typedef struct packed {
        logic             motor_up;
        logic             motor_down;
        logic [POS_W-1:0] position;
        logic             report_valid;
    } res_t;

endpackage

FILE: hw/rtl/tspc_cfg.sv
// ----------------------------------------------------------------------------
// tspc_cfg
// APB register file: travel time and the derived per-step length in ms.
// ----------------------------------------------------------------------------
module tspc_cfg (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [tspc_pkg::ADDR_W-1:0]  paddr,
    input  logic [tspc_pkg::DATA_W-1:0]  pwdata,
    output logic [tspc_pkg::DATA_W-1:0]  prdata,
    output logic                         pready,
    output logic [tspc_pkg::STEP_W-1:0]  step_len
);

    logic [tspc_pkg::TRAVEL_W-1:0] travel_reg;
    logic [tspc_pkg::STEP_W-1:0]   step_reg;
    logic [tspc_pkg::PROD_W-1:0]   prod;
    logic                          wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && (paddr[2] == tspc_pkg::REG_TRAVEL);

    // step = travel / 100 via reciprocal multiply
    assign prod = {{tspc_pkg::RECIP_W{1'b0}}, pwdata[tspc_pkg::TRAVEL_W-1:0]}
                * {{tspc_pkg::TRAVEL_W{1'b0}}, tspc_pkg::STEP_RECIP};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            travel_reg <= tspc_pkg::TRAVEL_RESET;
            step_reg   <= tspc_pkg::STEP_RESET;
        end
        else if (wr_en)
        begin
            travel_reg <= pwdata[tspc_pkg::TRAVEL_W-1:0];
            step_reg   <= prod[tspc_pkg::SHIFT+tspc_pkg::STEP_W-1:tspc_pkg::SHIFT];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == tspc_pkg::REG_TRAVEL)
        begin
            prdata = {{(tspc_pkg::DATA_W-tspc_pkg::TRAVEL_W){1'b0}}, travel_reg};
        end
    end

    assign step_len = step_reg;

endmodule

FILE: hw/rtl/tspc_core.sv
// ----------------------------------------------------------------------------
// tspc_core
// Target, position estimate, motion and step timer; one tick per enable.
// ----------------------------------------------------------------------------
module tspc_core (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  tspc_pkg::cmd_t              item,
    input  logic [tspc_pkg::STEP_W-1:0] step_len,
    output tspc_pkg::res_t              result
);

    typedef enum logic [1:0] {
        MOT_IDLE = 2'd0,
        MOT_UP   = 2'd1,
        MOT_DOWN = 2'd2
    } motion_t;

    logic [tspc_pkg::POS_W-1:0]  target_reg, target_next;
    logic [tspc_pkg::POS_W-1:0]  est_reg, est_next;
    logic [tspc_pkg::STEP_W-1:0] timer_reg, timer_next;
    motion_t                     motion_reg, motion_next;

    logic [tspc_pkg::POS_W-1:0]  tgt_cmd;
    logic [tspc_pkg::POS_W-1:0]  est_btn;
    logic [tspc_pkg::STEP_W-1:0] timer_inc;
    logic [tspc_pkg::STEP_W-1:0] timer_a;
    logic                        changed;
    logic                        step;

    always_comb
    begin
        case (item.command)
            tspc_pkg::CMD_UP:   tgt_cmd = '0;
            tspc_pkg::CMD_DOWN: tgt_cmd = tspc_pkg::POS_MAX;
            tspc_pkg::CMD_STOP: tgt_cmd = est_reg;
            default:            tgt_cmd = target_reg;
        endcase

        target_next = tgt_cmd;
        est_btn     = est_reg;
        if (item.up_button && !item.down_button)
        begin
            target_next = (est_reg == '0) ? '0 : est_reg - 7'd1;
            if (est_reg == '0)
            begin
                est_btn = 7'd1;
            end
        end
        else if (item.down_button && !item.up_button)
        begin
            target_next = (est_reg >= tspc_pkg::POS_MAX) ? tspc_pkg::POS_MAX
                                                          : est_reg + 7'd1;
            if (est_reg == tspc_pkg::POS_MAX)
            begin
                est_btn = tspc_pkg::POS_MAX - 7'd1;
            end
        end

        timer_inc = (timer_reg == tspc_pkg::TIMER_MAX) ? timer_reg : timer_reg + 14'd1;

        if (target_next > est_btn)
        begin
            motion_next = MOT_DOWN;
        end
        else if (target_next < est_btn)
        begin
            motion_next = MOT_UP;
        end
        else
        begin
            motion_next = MOT_IDLE;
        end

        changed = (motion_next != motion_reg);
        timer_a = changed ? '0 : timer_inc;
        step    = (timer_a >= step_len);

        est_next   = est_btn;
        timer_next = timer_a;
        if (step)
        begin
            timer_next = '0;
            case (motion_next)
                MOT_DOWN: est_next = est_btn + 7'd1;
                MOT_UP:   est_next = est_btn - 7'd1;
                default:  est_next = est_btn;
            endcase
        end

        result.motor_up     = (motion_next == MOT_UP);
        result.motor_down   = (motion_next == MOT_DOWN);
        result.position     = est_next;
        result.report_valid = changed && (motion_next == MOT_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg <= '0;
            est_reg    <= '0;
            timer_reg  <= '0;
            motion_reg <= MOT_IDLE;
        end
        else if (en)
        begin
            target_reg <= target_next;
            est_reg    <= est_next;
            timer_reg  <= timer_next;
            motion_reg <= motion_next;
        end
    end

endmodule

FILE: hw/rtl/timed_shutter_position_controller_unit.sv
// ----------------------------------------------------------------------------
// timed_shutter_position_controller_unit
// Millisecond-tick shutter controller: one result beat per input beat.
//
// Input channel (cmd_valid/cmd_stall/cmd_data) carries one tick: remote
// command plus the two wall buttons. Output channel (res_valid/res_stall/
// res_data) returns motor drive, estimated position and a stop report.
// A beat lands in an input register, the state update runs in one
// combinational pass, and the result is held in an output register:
// res_valid rises once the beat has moved from the input register into the
// output register; throughput 1 beat per cycle while the receiver does not
// stall.
// When the receiver stalls, the output register holds its beat and the
// input register takes one more; cmd_stall rises only when both are full.
// Reset clears state to position 0 (fully up), idle, travel time 27000 ms.
// APB register 0 at address 0 is the travel time; the step length is
// derived at write time, so writes take effect for the next beat.
// ----------------------------------------------------------------------------
module timed_shutter_position_controller_unit (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cmd_valid,
    output logic                        cmd_stall,
    input  tspc_pkg::cmd_t              cmd_data,
    output logic                        res_valid,
    input  logic                        res_stall,
    output tspc_pkg::res_t              res_data,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [tspc_pkg::ADDR_W-1:0] paddr,
    input  logic [tspc_pkg::DATA_W-1:0] pwdata,
    output logic [tspc_pkg::DATA_W-1:0] prdata,
    output logic                        pready
);

    logic                        in_valid_reg;
    tspc_pkg::cmd_t              in_data_reg;
    logic                        out_valid_reg;
    tspc_pkg::res_t              out_data_reg;
    logic                        advance;
    logic                        take;
    tspc_pkg::res_t              result;
    logic [tspc_pkg::STEP_W-1:0] step_len;

    assign advance   = in_valid_reg && (!out_valid_reg || !res_stall);
    assign cmd_stall = in_valid_reg && !advance;
    assign take      = cmd_valid && !cmd_stall;

    tspc_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .step_len (step_len)
    );

    tspc_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (advance),
        .item     (in_data_reg),
        .step_len (step_len),
        .result   (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!res_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            in_data_reg <= cmd_data;
        end
        if (advance)
        begin
            out_data_reg <= result;
        end
    end

    assign res_valid = out_valid_reg;
    assign res_data  = out_data_reg;

    a_motor_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> !(res_data.motor_up && res_data.motor_down))
        else $error("both directions driven");

    a_report_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_data.report_valid)
            |-> (!res_data.motor_up && !res_data.motor_down))
        else $error("report while motor runs");

    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (res_data.position <= tspc_pkg::POS_MAX))
        else $error("position out of range");

    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_stall |-> (in_valid_reg && out_valid_reg && res_stall))
        else $error("stall with free buffer");

endmodule

FILE: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the timed shutter position controller.
//
// Each input beat is one millisecond tick: remote command plus wall buttons.
// A tick-accurate predictor tracks goal, estimated position, drive direction
// and the step counter. Every result beat is compared with the predicted one,
// or with the typed one where a directed row gives it. A short directed table
// runs first. Random button and command sequences follow, at several travel
// times including the range ends, with sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb;

    typedef enum logic [1:0] {
        DRIVE_IDLE = 2'd0,
        DRIVE_UP   = 2'd1,
        DRIVE_DOWN = 2'd2
    } drive_t;

    typedef struct packed {
        tspc_pkg::cmd_t tick;
        logic           typed;
        tspc_pkg::res_t want;
    } step_row_t;

    localparam logic [tspc_pkg::ADDR_W-1:0] ADDR_TRAVEL = {tspc_pkg::REG_TRAVEL, 2'b00};
    localparam logic [tspc_pkg::ADDR_W-1:0] ADDR_SPARE  = 3'd4;
    localparam int                          N_PHASES    = 9;
    localparam int                          N_ROWS      = 16;

    logic                        clk       = 1'b0;
    logic                        rst_n     = 1'b0;
    logic                        cmd_valid = 1'b0;
    logic                        cmd_stall;
    tspc_pkg::cmd_t              cmd_data  = '0;
    logic                        res_valid;
    logic                        res_stall = 1'b0;
    tspc_pkg::res_t              res_data;
    logic                        psel      = 1'b0;
    logic                        penable   = 1'b0;
    logic                        pwrite    = 1'b0;
    logic [tspc_pkg::ADDR_W-1:0] paddr     = '0;
    logic [tspc_pkg::DATA_W-1:0] pwdata    = '0;
    logic [tspc_pkg::DATA_W-1:0] prdata;
    logic                        pready;

    // predicted controller state
    logic [tspc_pkg::POS_W-1:0]    pos_est   = '0;
    logic [tspc_pkg::POS_W-1:0]    pos_goal  = '0;
    drive_t                        drive     = DRIVE_IDLE;
    logic [tspc_pkg::STEP_W-1:0]   ms_count  = '0;
    logic [tspc_pkg::TRAVEL_W-1:0] travel_ms = tspc_pkg::TRAVEL_RESET;

    tspc_pkg::res_t expected_res[$];
    int             mismatches     = 0;
    int             beats_checked  = 0;
    int             ticks_sent     = 0;
    int             travel_writes  = 0;
    int             send_gap_pct   = 0;
    int             recv_stall_pct = 0;

    // directed ticks; want is typed only where it is obvious from reset state
    step_row_t directed_steps [N_ROWS] = '{
        '{'{tspc_pkg::CMD_NONE, 1'b0, 1'b0}, 1'b1, '{1'b0, 1'b0, 7'd0, 1'b0}},
        '{'{tspc_pkg::CMD_NONE, 1'b0, 1'b1}, 1'b1, '{1'b0, 1'b1, 7'd0, 1'b0}},
        '{'{tspc_pkg::CMD_NONE, 1'b1, 1'b1}, 1'b0, '0},
        '{'{tspc_pkg::CMD_STOP, 1'b0, 1'b0}, 1'b1, '{1'b0, 1'b0, 7'd0, 1'b1}},
        '{'{tspc_pkg::CMD_NONE, 1'b1, 1'b0}, 1'b1, '{1'b1, 1'b0, 7'd1, 1'b0}},
        '{'{tspc_pkg::CMD_UP,   1'b0, 1'b1}, 1'b1, '{1'b0, 1'b1, 7'd1, 1'b0}},
        '{'{tspc_pkg::CMD_DOWN, 1'b0, 1'b0}, 1'b0, '0},
        '{'{tspc_pkg::CMD_STOP, 1'b1, 1'b0}, 1'b0, '0},
        '{'{tspc_pkg::CMD_UP,   1'b0, 1'b0}, 1'b0, '0},
        '{'{tspc_pkg::CMD_NONE, 1'b0, 1'b0}, 1'b0, '0},
        '{'{tspc_pkg::CMD_DOWN, 1'b1, 1'b1}, 1'b0, '0},
        '{'{tspc_pkg::CMD_STOP, 1'b1, 1'b1}, 1'b0, '0},
        '{'{tspc_pkg::CMD_STOP, 1'b0, 1'b0}, 1'b0, '0},
        '{'{tspc_pkg::CMD_DOWN, 1'b0, 1'b0}, 1'b0, '0},
        '{'{tspc_pkg::CMD_UP,   1'b0, 1'b0}, 1'b0, '0},
        '{'{tspc_pkg::CMD_STOP, 1'b0, 1'b0}, 1'b0, '0}
    };

    // travel settings: below the step floor, low end, field max, high end
    logic [tspc_pkg::DATA_W-1:0] phase_wdata [N_PHASES] = '{
        32'd50, 32'd100, 32'd350, 32'd0, 32'd1000000, 32'h000F_FFFF,
        32'd1200, 32'd99, 32'hFFF0_02BC
    };
    int phase_ticks [N_PHASES] = '{150, 110, 70, 120, 30, 30, 60, 80, 50};

    always #4 clk = ~clk;

    timed_shutter_position_controller_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd_data  (cmd_data),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    function automatic tspc_pkg::res_t shutter_tick(input tspc_pkg::cmd_t c);
        tspc_pkg::res_t r;
        drive_t         nxt;
        int             step_ms;
        logic           stop_edge;
        case (c.command)
            tspc_pkg::CMD_UP:   pos_goal = '0;
            tspc_pkg::CMD_DOWN: pos_goal = tspc_pkg::POS_MAX;
            tspc_pkg::CMD_STOP: pos_goal = pos_est;
            default:            ;
        endcase
        // buttons override the command; both held means neither
        if (c.up_button && !c.down_button)
        begin
            pos_goal = (pos_est == 0) ? '0 : pos_est - 1'b1;
            if (pos_est == 0)
                pos_est = 7'd1;
        end
        else if (c.down_button && !c.up_button)
        begin
            pos_goal = (pos_est >= tspc_pkg::POS_MAX) ? tspc_pkg::POS_MAX : pos_est + 1'b1;
            if (pos_est == tspc_pkg::POS_MAX)
                pos_est = tspc_pkg::POS_MAX - 1'b1;
        end
        if (ms_count < tspc_pkg::TIMER_MAX)
            ms_count = ms_count + 1'b1;
        if (pos_goal > pos_est)
            nxt = DRIVE_DOWN;
        else if (pos_goal < pos_est)
            nxt = DRIVE_UP;
        else
            nxt = DRIVE_IDLE;
        stop_edge = 1'b0;
        if (nxt != drive)
        begin
            ms_count  = '0;
            stop_edge = (nxt == DRIVE_IDLE);
        end
        drive   = nxt;
        step_ms = int'(travel_ms) / 100;
        if (int'(ms_count) >= step_ms)
        begin
            if (pos_goal > pos_est)
                pos_est = pos_est + 1'b1;
            else if (pos_goal < pos_est)
                pos_est = pos_est - 1'b1;
            ms_count = '0;
        end
        r.motor_up     = (drive == DRIVE_UP);
        r.motor_down   = (drive == DRIVE_DOWN);
        r.position     = pos_est;
        r.report_valid = stop_edge;
        return r;
    endfunction

    task automatic apply_tick(input tspc_pkg::cmd_t c, input logic typed,
                              input tspc_pkg::res_t want);
        tspc_pkg::res_t predicted;
        while ($urandom_range(99) < send_gap_pct)
        begin
            cmd_valid <= 1'b0;
            @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd_data  <= c;
        @(posedge clk);
        while (cmd_stall !== 1'b0)
            @(posedge clk);
        predicted = shutter_tick(c);
        expected_res.push_back(typed ? want : predicted);
        ticks_sent++;
    endtask

    // register write plus read-back of the travel time; only while drained
    task automatic write_reg(input logic [tspc_pkg::ADDR_W-1:0] addr,
                             input logic [tspc_pkg::DATA_W-1:0] value);
        cmd_valid <= 1'b0;
        @(posedge clk);
        while (expected_res.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (addr == ADDR_TRAVEL)
        begin
            travel_ms = value[tspc_pkg::TRAVEL_W-1:0];
            travel_writes++;
        end
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_TRAVEL;
        @(posedge clk);
        penable <= 1'b1;
        @(negedge clk);
        if (prdata[tspc_pkg::TRAVEL_W-1:0] !== travel_ms)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("travel read-back: expected %0d got %0d",
                         travel_ms, prdata[tspc_pkg::TRAVEL_W-1:0]);
        end
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    always @(posedge clk)
        res_stall <= ($urandom_range(99) < recv_stall_pct);

    always @(posedge clk)
    begin : check_beat
        tspc_pkg::res_t want;
        if (rst_n && res_valid && !res_stall)
        begin
            beats_checked++;
            if (expected_res.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected beat: up=%0b down=%0b pos=%0d rep=%0b",
                             res_data.motor_up, res_data.motor_down,
                             res_data.position, res_data.report_valid);
            end
            else
            begin
                want = expected_res.pop_front();
                if (res_data.motor_up !== want.motor_up
                    || res_data.motor_down !== want.motor_down
                    || res_data.position !== want.position
                    || res_data.report_valid !== want.report_valid)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"beat %0d: expected up=%0b down=%0b pos=%0d rep=%0b,",
                                  " got up=%0b down=%0b pos=%0d rep=%0b"},
                                 beats_checked, want.motor_up, want.motor_down,
                                 want.position, want.report_valid,
                                 res_data.motor_up, res_data.motor_down,
                                 res_data.position, res_data.report_valid);
                end
            end
        end
    end

    initial
    begin
        int             kind;
        int             len;
        int             done;
        logic           dir;
        tspc_pkg::cmd_t t;
        send_gap_pct   = 12;
        recv_stall_pct = 65;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < N_ROWS; i++)
            apply_tick(directed_steps[i].tick, directed_steps[i].typed,
                       directed_steps[i].want);

        for (int p = 0; p < N_PHASES; p++)
        begin
            send_gap_pct   = (p < 3) ? 12 : (p < 6) ? 65 : 0;
            recv_stall_pct = (p < 3) ? 65 : (p < 6) ? 12 : 0;
            if (p == 6)
                write_reg(ADDR_SPARE, 32'h0005_A5A5);
            write_reg(ADDR_TRAVEL, phase_wdata[p]);
            done = 0;
            while (done < phase_ticks[p])
            begin
                kind = $urandom_range(99);
                dir  = 1'($urandom_range(1));
                len  = ($urandom_range(99) < 30) ? $urandom_range(20, 150)
                                                 : $urandom_range(1, 8);
                if (len > phase_ticks[p] - done)
                    len = phase_ticks[p] - done;
                for (int k = 0; k < len; k++)
                begin
                    t = '0;
                    if (kind < 35)
                    begin
                        if (k == 0)
                            t.command = dir ? tspc_pkg::CMD_DOWN : tspc_pkg::CMD_UP;
                    end
                    else if (kind < 55)
                    begin
                        // held button, released on the last tick
                        if (k < len - 1)
                        begin
                            t.up_button   = !dir;
                            t.down_button = dir;
                        end
                    end
                    else if (kind < 65)
                    begin
                        if (k == 0)
                            t.command = tspc_pkg::CMD_STOP;
                    end
                    else if (kind < 75)
                    begin
                        t.command     = 2'($urandom_range(3));
                        t.up_button   = !dir;
                        t.down_button = dir;
                    end
                    else
                        t = tspc_pkg::cmd_t'(4'($urandom_range(15)));
                    apply_tick(t, 1'b0, '0);
                    done++;
                end
            end
        end

        cmd_valid <= 1'b0;
        while (expected_res.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        $display("%0d ticks over %0d travel settings, %0d result beats compared",
                 ticks_sent, travel_writes + 1, beats_checked);
        if (mismatches == 0 && expected_res.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
